### rtl/core/fstm_pkg.sv
// Package for the flat span texture mapper.
// Holds the item and result structs, action and register codes and sizing constants.
// No dependencies.
package fstm_pkg;

  localparam int unsigned TEXEL_DEPTH_DEF = 4096;
  localparam int unsigned SCREEN_SPAN_DEF = 2048;
  localparam int unsigned SHADE_DEPTH     = 256;
  localparam int unsigned BLEND_DEPTH     = 65536;
  localparam int unsigned OUT_FIFO_DEPTH  = 8;

  typedef enum logic [2:0] {
    ACT_LOAD_TEXEL = 3'd0,
    ACT_LOAD_SHADE = 3'd1,
    ACT_LOAD_BLEND = 3'd2,
    ACT_START_SPAN = 3'd3,
    ACT_DRAW_PIXEL = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    CFG_START_SHIFT  = 3'd0,
    CFG_COLUMN_SHIFT = 3'd1,
    CFG_ROW_SHIFT    = 3'd2,
    CFG_ROW_MASK     = 3'd3,
    CFG_TRANSLUCENT  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] address;
    logic [7:0]  data;
    logic [31:0] x_start;
    logic [31:0] y_start;
    logic [31:0] x_delta;
    logic [31:0] y_delta;
    logic [10:0] screen_row;
    logic [10:0] first_column;
    logic [10:0] last_column;
    logic [7:0]  background;
  } fstm_in_t;

  typedef struct packed {
    logic [7:0]  pixel;
    logic [10:0] column;
    logic [10:0] row;
    logic        span_end;
  } fstm_out_t;

  typedef struct packed {
    logic [10:0] column;
    logic [10:0] row;
    logic        span_end;
    logic [7:0]  background;
  } fstm_meta_t;

endpackage

### rtl/core/flat_span_texture_mapper.sv
// Flat span texture mapper top level: accumulators, texel/shade/blend memories,
// read pipeline and output queue. Depends on fstm_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries load, span start
//   and draw items. Loads fill the texel store, shade table and blend table; a
//   span start loads the accumulators and column range; each draw item inside a
//   span yields one result on the output channel (out_valid_o / out_stall_i).
//   Configuration registers are written through cfg_valid_i / cfg_ready_o with
//   cfg_index_i and cfg_data_i while the block is idle; cfg_ready_o is always high.
//   Pipeline: a drawn pixel passes registered texel, shade and blend memory
//   reads in turn and then enters the output queue.
//   Throughput: one item per clock while in_stall_o is low; the memory reads are
//   issued every cycle, and each accumulator step is a single 32-bit add.
//   Results enter an eight-entry queue. When the receiver stalls, the queue fills
//   and in_stall_o rises once queued plus in-flight results reach its depth.
//   Reset clears span state, the queue and the registers to their defaults.
//   Table contents are undefined until loaded; there is no clearing pass.
module flat_span_texture_mapper
  import fstm_pkg::*;
#(
  parameter int unsigned TEXEL_DEPTH = TEXEL_DEPTH_DEF,
  parameter int unsigned SCREEN_SPAN = SCREEN_SPAN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  fstm_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output fstm_out_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  localparam int unsigned TW    = $clog2(TEXEL_DEPTH);
  localparam int unsigned PTR_W = $clog2(OUT_FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(OUT_FIFO_DEPTH + 1);
  localparam int unsigned SW    = $clog2(SHADE_DEPTH);
  localparam int unsigned BW    = $clog2(BLEND_DEPTH);
  localparam logic [31:0] SPAN_LIMIT = 32'(SCREEN_SPAN);

  // configuration
  logic [4:0]  start_shift_q, column_shift_q, row_shift_q;
  logic [11:0] row_mask_q;
  logic        translucent_q;

  // span state
  logic [31:0] x_accum_q, y_accum_q, x_incr_q, y_incr_q;
  logic [10:0] cur_col_q, end_col_q, span_row_q;
  logic        span_active_q;

  // pipeline
  logic        p1_valid_q, p2_valid_q, p3_valid_q;
  fstm_meta_t  p1_meta_q, p2_meta_q, p3_meta_q;
  logic [7:0]  p3_shade_q;

  // memories
  logic [7:0]  texel_mem [TEXEL_DEPTH];
  logic [7:0]  shade_mem [SHADE_DEPTH];
  logic [7:0]  blend_mem [BLEND_DEPTH];
  logic [7:0]  texel_rd_q, shade_rd_q, blend_rd_q;
  logic        bw_valid_q;
  logic [BW-1:0] bw_addr_q;
  logic [7:0]  bw_data_q;

  // output queue
  fstm_out_t        fifo_q [OUT_FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] fifo_cnt_q;

  logic        accept, pop, push, is_draw;
  logic [CNT_W-1:0] pending;
  logic [31:0] row_part, col_part, tex_idx;
  logic [TW+15:0] load_addr_ext;
  logic [31:0] first32, last32, last_sat;
  logic        start_ok;
  fstm_out_t   push_data;

  assign cfg_ready_o = 1'b1;
  assign pending     = fifo_cnt_q + CNT_W'(p1_valid_q) + CNT_W'(p2_valid_q)
                     + CNT_W'(p3_valid_q);
  assign in_stall_o  = (pending >= CNT_W'(OUT_FIFO_DEPTH));
  assign accept      = in_valid_i && !in_stall_o;
  assign is_draw     = accept && (in_data_i.action == ACT_DRAW_PIXEL) && span_active_q;

  assign row_part = (y_accum_q >> row_shift_q) & {20'd0, row_mask_q};
  assign col_part = x_accum_q >> column_shift_q;
  assign tex_idx  = row_part | col_part;
  assign load_addr_ext = {{TW{1'b0}}, in_data_i.address};

  assign first32  = {21'd0, in_data_i.first_column};
  assign last32   = {21'd0, in_data_i.last_column};
  assign last_sat = (last32 > SPAN_LIMIT - 32'd1) ? SPAN_LIMIT - 32'd1 : last32;
  assign start_ok = (first32 < SPAN_LIMIT) && (last_sat >= first32);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_shift_q  <= 5'd10;
      column_shift_q <= 5'd26;
      row_shift_q    <= 5'd20;
      row_mask_q     <= 12'd4032;
      translucent_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_START_SHIFT:  start_shift_q  <= cfg_data_i[4:0];
        CFG_COLUMN_SHIFT: column_shift_q <= cfg_data_i[4:0];
        CFG_ROW_SHIFT:    row_shift_q    <= cfg_data_i[4:0];
        CFG_ROW_MASK:     row_mask_q     <= cfg_data_i;
        CFG_TRANSLUCENT:  translucent_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_accum_q     <= '0;
      y_accum_q     <= '0;
      x_incr_q      <= '0;
      y_incr_q      <= '0;
      cur_col_q     <= '0;
      end_col_q     <= '0;
      span_row_q    <= '0;
      span_active_q <= 1'b0;
    end else if (accept) begin
      case (in_data_i.action)
        ACT_START_SPAN: begin
          x_accum_q     <= in_data_i.x_start << start_shift_q;
          y_accum_q     <= in_data_i.y_start << start_shift_q;
          x_incr_q      <= in_data_i.x_delta << start_shift_q;
          y_incr_q      <= in_data_i.y_delta << start_shift_q;
          span_row_q    <= in_data_i.screen_row;
          cur_col_q     <= in_data_i.first_column;
          end_col_q     <= last_sat[10:0];
          span_active_q <= start_ok;
        end
        ACT_DRAW_PIXEL: begin
          if (span_active_q) begin
            x_accum_q <= x_accum_q + x_incr_q;
            y_accum_q <= y_accum_q + y_incr_q;
            if (cur_col_q == end_col_q) begin
              span_active_q <= 1'b0;
            end else begin
              cur_col_q <= cur_col_q + 11'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // texel store: written at transfer, read with the accumulator index
  always_ff @(posedge clk_i) begin
    if (accept && (in_data_i.action == ACT_LOAD_TEXEL)) begin
      texel_mem[load_addr_ext[TW-1:0]] <= in_data_i.data;
    end
    texel_rd_q <= texel_mem[tex_idx[TW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (accept && (in_data_i.action == ACT_LOAD_SHADE)) begin
      shade_mem[in_data_i.address[SW-1:0]] <= in_data_i.data;
    end
    shade_rd_q <= shade_mem[texel_rd_q];
  end

  // blend writes are held in a register so a pixel ahead of the load reads old data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_valid_q <= 1'b0;
    end else begin
      bw_valid_q <= accept && (in_data_i.action == ACT_LOAD_BLEND);
    end
  end

  always_ff @(posedge clk_i) begin
    bw_addr_q <= in_data_i.address[BW-1:0];
    bw_data_q <= in_data_i.data;
  end

  always_ff @(posedge clk_i) begin
    if (bw_valid_q) begin
      blend_mem[bw_addr_q] <= bw_data_q;
    end
    blend_rd_q <= blend_mem[{shade_rd_q, p2_meta_q.background}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      p3_valid_q <= 1'b0;
    end else begin
      p1_valid_q <= is_draw;
      p2_valid_q <= p1_valid_q;
      p3_valid_q <= p2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_meta_q.column     <= cur_col_q;
    p1_meta_q.row        <= span_row_q;
    p1_meta_q.span_end   <= (cur_col_q == end_col_q);
    p1_meta_q.background <= in_data_i.background;
    p2_meta_q            <= p1_meta_q;
    p3_meta_q            <= p2_meta_q;
    p3_shade_q           <= shade_rd_q;
  end

  assign push = p3_valid_q;
  assign pop  = out_valid_o && !out_stall_i;

  always_comb begin
    push_data.pixel    = translucent_q ? blend_rd_q : p3_shade_q;
    push_data.column   = p3_meta_q.column;
    push_data.row      = p3_meta_q.row;
    push_data.span_end = p3_meta_q.span_end;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + CNT_W'(push) - CNT_W'(pop);
    end
  end

  assign out_valid_o = (fifo_cnt_q != '0);
  assign out_data_o  = fifo_q[rd_ptr_q];

  // queue never holds more than its depth
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= CNT_W'(OUT_FIFO_DEPTH))
    else $error("output queue overflow");

  // a finishing pixel always finds room in the queue
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p3_valid_q |-> (fifo_cnt_q < CNT_W'(OUT_FIFO_DEPTH)))
    else $error("pixel pushed into full queue");

  // draw outside a span issues nothing
  a_no_span_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.action == ACT_DRAW_PIXEL) && !span_active_q) |=> !p1_valid_q)
    else $error("pixel issued without span");

  // the last pixel of a span closes it
  a_span_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p1_valid_q && p1_meta_q.span_end) |-> !span_active_q)
    else $error("span still active after its last pixel");

  // in-flight results never exceed the credit limit
  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending <= CNT_W'(OUT_FIFO_DEPTH))
    else $error("credit limit exceeded");

endmodule
